// ===== rtl/pausable_countdown_timer_top_macros.svh =====
`ifndef PAUSABLE_COUNTDOWN_TIMER_TOP_MACROS_SVH
`define PAUSABLE_COUNTDOWN_TIMER_TOP_MACROS_SVH

// Each macro expects signals named clk and rst_n in the module that uses it.

`define PCDT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define PCDT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define PCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pcdt_pkg.sv =====
`default_nettype none

package pcdt_pkg;

  localparam int FUNC_W  = 3;
  localparam int MIN_W   = 10;
  localparam int SECS_W  = 16;
  localparam int PHASE_W = 10;
  localparam int PCT_W   = 7;
  localparam int NUM_W   = 23;

  localparam int MAX_MINUTES      = 1023;
  localparam int TICKS_PER_SECOND = 1000;
  localparam int SECS_PER_MIN     = 60;
  localparam int PCT_SCALE        = 100;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_START  = 3'd1,
    FN_SET    = 3'd2,
    FN_PAUSE  = 3'd3,
    FN_RESUME = 3'd4,
    FN_STOP   = 3'd5
  } func_t;

endpackage

`default_nettype wire

// ===== rtl/pcdt_ifs.sv =====
`default_nettype none

interface pcdt_in_if;
  import pcdt_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [MIN_W-1:0]   minutes;

  modport source (output valid, func, minutes, input ready);
  modport sink   (input valid, func, minutes, output ready);
endinterface

interface pcdt_out_if;
  import pcdt_pkg::*;

  logic               valid;
  logic               ready;
  logic [SECS_W-1:0]  remaining_secs;
  logic [PCT_W-1:0]   percent_elapsed;
  logic               running;
  logic               held;
  logic               finished;

  modport source (output valid, remaining_secs, percent_elapsed, running, held, finished,
                  input ready);
  modport sink   (input valid, remaining_secs, percent_elapsed, running, held, finished,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/pausable_countdown_timer_top.sv =====
// Countdown timer set in minutes and driven by millisecond tick requests.
// Input channel in_ch carries func (tick, start, set duration, pause, resume,
// stop) and minutes; the result channel out_ch returns one result per request
// with the remaining seconds, percent elapsed, running, held and finished.
// Both channels use valid/ready; a request moves on an edge where both are high.
// The timer state is updated on the accepting edge itself. A valid result then
// follows: the LOAD state forms the scaled elapsed time and starts the divider,
// the compare-and-subtract divider produces the percentage (one quotient bit per
// cycle), the DIV state hands the quotient over when it is done, and the PUSH
// state loads the output register.
// The next request is accepted once the previous result sits in the output
// register, so a new request is not taken while the previous one is in progress.
// If the receiver stalls, the result holds in the output register and one more
// request can be processed; it then waits until the register is free.
// Synchronous reset clears the timer to inactive, unpaused, zero duration,
// zero remaining time and zero phase, and empties the output register.
`default_nettype none

module pausable_countdown_timer_top (
  input  logic        clk,
  input  logic        rst_n,
  pcdt_in_if.sink     in_ch,
  pcdt_out_if.source  out_ch
);
  import pcdt_pkg::*;

`include "pausable_countdown_timer_top_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_PUSH
  } state_t;

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(PCT_SCALE);

  state_t             state_r, state_nxt;
  logic               active_r, active_nxt;
  logic               paused_r, paused_nxt;
  logic [SECS_W-1:0]  dur_r, dur_nxt;
  logic [SECS_W-1:0]  left_r, left_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               fin_r, fin_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SECS_W-1:0]  left_o_r;
  logic [PCT_W-1:0]   pct_o_r;
  logic               run_o_r;
  logic               held_o_r;
  logic               fin_o_r;

  logic               accept;
  logic               push;
  func_t              func;
  logic [MIN_W-1:0]   min_sat;
  logic [SECS_W-1:0]  new_secs;
  logic [PHASE_W-1:0] phase_inc;
  logic [SECS_W:0]    sum;
  logic [SECS_W:0]    excess;
  logic [NUM_W-1:0]   div_num;
  logic               div_start;
  logic               div_done;
  logic [PCT_W-1:0]   div_quot;
  logic [PCT_W-1:0]   pct;

  assign accept    = in_ch.valid && in_ch.ready;
  assign func      = func_t'(in_ch.func);
  assign min_sat   = (in_ch.minutes > MIN_W'(MAX_MINUTES)) ? MIN_W'(MAX_MINUTES)
                                                            : in_ch.minutes;
  assign new_secs  = SECS_W'(min_sat) * SECS_W'(SECS_PER_MIN);
  assign phase_inc = phase_r + 1'b1;
  assign sum       = {1'b0, left_r} + {1'b0, new_secs};
  assign excess    = sum - {1'b0, dur_r};

  always_comb begin
    active_nxt = active_r;
    paused_nxt = paused_r;
    dur_nxt    = dur_r;
    left_nxt   = left_r;
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    if (accept) begin
      fin_nxt = 1'b0;
      case (func)
        FN_TICK: begin
          if (active_r && !paused_r) begin
            phase_nxt = phase_inc;
            if (phase_inc >= PHASE_W'(TICKS_PER_SECOND)) begin
              phase_nxt = '0;
              if (left_r != '0) begin
                left_nxt = left_r - 1'b1;
              end
              if (left_r <= SECS_W'(1)) begin
                active_nxt = 1'b0;
                fin_nxt    = 1'b1;
              end
            end
          end
        end
        FN_START: begin
          dur_nxt    = new_secs;
          left_nxt   = new_secs;
          active_nxt = 1'b1;
          paused_nxt = 1'b0;
          phase_nxt  = '0;
        end
        FN_SET: begin
          if (left_r > new_secs) begin
            left_nxt = new_secs;
          end else if (dur_r != '0) begin
            if (sum <= {1'b0, dur_r}) begin
              left_nxt = '0;
            end else if (excess[SECS_W]) begin
              left_nxt = '1;
            end else begin
              left_nxt = excess[SECS_W-1:0];
            end
          end else begin
            left_nxt = new_secs;
          end
          dur_nxt = new_secs;
        end
        FN_PAUSE: begin
          if (active_r && !paused_r) begin
            paused_nxt = 1'b1;
          end
        end
        FN_RESUME: begin
          if (active_r && paused_r) begin
            paused_nxt = 1'b0;
            phase_nxt  = '0;
          end
        end
        FN_STOP: begin
          active_nxt = 1'b0;
          paused_nxt = 1'b0;
          left_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign div_num   = NUM_W'(dur_r - left_r) * NUM_W'(PCT_SCALE);
  assign div_start = (state_r == ST_LOAD);
  assign pct       = ((dur_r == '0) || (left_r > dur_r)) ? '0 : div_quot;
  assign push      = (state_r == ST_PUSH) && (!out_valid_r || out_ch.ready);

  pcdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dur_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_PUSH;
      ST_PUSH: if (push) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      paused_r    <= 1'b0;
      dur_r       <= '0;
      left_r      <= '0;
      phase_r     <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      paused_r    <= paused_nxt;
      dur_r       <= dur_nxt;
      left_r      <= left_nxt;
      phase_r     <= phase_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (push) begin
      left_o_r <= left_r;
      pct_o_r  <= pct;
      run_o_r  <= active_r;
      held_o_r <= paused_r;
      fin_o_r  <= fin_r;
    end
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.remaining_secs  = left_o_r;
  assign out_ch.percent_elapsed = pct_o_r;
  assign out_ch.running         = run_o_r;
  assign out_ch.held            = held_o_r;
  assign out_ch.finished        = fin_o_r;

  `PCDT_ASSERT_ALWAYS(a_left_within_dur, left_r <= dur_r, "Remaining time exceeds duration.")
  `PCDT_ASSERT_IMPLY(a_held_needs_active, paused_r, active_r, "Paused while inactive.")
  `PCDT_ASSERT_IMPLY(a_pct_in_range, out_valid_r, pct_o_r <= PCT_MAX, "Percent above full scale.")
  `PCDT_ASSERT_IMPLY(a_fin_stopped, out_valid_r && fin_o_r, !run_o_r, "Finished while running.")
  `PCDT_ASSERT_NEXT(a_push_loads, push, out_valid_r && (state_r == ST_IDLE), "Result not loaded.")

endmodule

`default_nettype wire

// ===== rtl/pcdt_div.sv =====
`default_nettype none

module pcdt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pcdt_pkg::NUM_W-1:0]  num,
  input  logic [pcdt_pkg::SECS_W-1:0] den,
  output logic                      done,
  output logic [pcdt_pkg::PCT_W-1:0]  quot
);
  import pcdt_pkg::*;

  localparam int CNT_W = $clog2(PCT_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsh_r, dsh_nxt;
  logic [PCT_W-1:0] q_r, q_nxt;
  logic             fits;

  // One compare and subtract per cycle, one quotient bit per cycle.
  assign fits = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(PCT_W - 1);
      rem_nxt  = num;
      dsh_nxt  = NUM_W'(den) << (PCT_W - 1);
      q_nxt    = '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[PCT_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire
